// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file, lafc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held low.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lafc_pkg.sv -----
`default_nettype none

package lafc_pkg;

  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [CFG_DATA_W-1:0] layer_count_t;

  localparam alpha_t       FULL_ALPHA = 8'd255;
  localparam layer_count_t LC_RESET   = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION   = 1'b0,
    REG_LAYER_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    DIR_TO_ABS     = 1'b0,
    DIR_TO_STACKED = 1'b1
  } dir_t;

  // overlay one in the low byte
  typedef struct packed {
    alpha_t a3;
    alpha_t a2;
    alpha_t a1;
  } alpha_set_t;

  typedef struct packed {
    logic   sat;
    alpha_t a3;
    alpha_t a2;
    alpha_t a1;
  } res_t;

  typedef struct packed {
    logic vld;
    dir_t dir;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/layer_alpha_format_convert_top.sv -----
// The pipeline depth matches the stacked-to-absolute chain (multiply,
// then divide by 255, per overlay); out_tvalid is registered after it.
// Throughput: one pixel per cycle; a stall freezes the whole pipeline.
// Reset (rst_n low, synchronous): direction 0, layer_count 4, pipeline and
// output empty; in_tready is high from the first cycle after reset.
`default_nettype none

module layer_alpha_format_convert_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // alpha_in_1 [7:0], alpha_in_2 [15:8], alpha_in_3 [23:16]
  input  logic [lafc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // alpha_out_1 [7:0], alpha_out_2 [15:8], alpha_out_3 [23:16], saturated [24]
  output logic [lafc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [lafc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lafc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lafc_pkg::*;

  localparam int unsigned PIPE_DEPTH = 7;

  dir_t         direction_r;
  layer_count_t layer_count_r;

  alpha_set_t in_alpha, alpha_s1_nxt, alpha_s1_r;
  ctl_t       ctl_r [PIPE_DEPTH];
  logic       pipe_en;
  res_t       abs_res, stk_res, pipe_res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= DIR_TO_ABS;
      layer_count_r <= LC_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIRECTION:   direction_r   <= dir_t'(cfg_wdata[0]);
        REG_LAYER_COUNT: layer_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // overlays beyond the active count enter as zero alpha
  always_comb begin
    in_alpha        = alpha_set_t'(in_tdata);
    alpha_s1_nxt.a1 = (layer_count_r >= 3'd2) ? in_alpha.a1 : '0;
    alpha_s1_nxt.a2 = (layer_count_r >= 3'd3) ? in_alpha.a2 : '0;
    alpha_s1_nxt.a3 = (layer_count_r >= 3'd4) ? in_alpha.a3 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        ctl_r[i] <= '{vld: 1'b0, dir: DIR_TO_ABS};
      end
    end else if (pipe_en) begin
      ctl_r[0] <= '{vld: in_tvalid, dir: direction_r};
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      alpha_s1_r <= alpha_s1_nxt;
    end
  end

  lafc_abs_chain u_abs (
    .clk     (clk),
    .en      (pipe_en),
    .alpha_i (alpha_s1_r),
    .res_o   (abs_res)
  );

  lafc_stk_lanes u_stk (
    .clk     (clk),
    .en      (pipe_en),
    .alpha_i (alpha_s1_r),
    .res_o   (stk_res)
  );

  assign pipe_res = (ctl_r[PIPE_DEPTH-1].dir == DIR_TO_STACKED) ? stk_res : abs_res;

  lafc_out_skid u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .pipe_vld (ctl_r[PIPE_DEPTH-1].vld),
    .pipe_res (pipe_res),
    .pipe_en  (pipe_en),
    .out_vld  (out_tvalid),
    .out_res  (out_res),
    .out_rdy  (out_tready)
  );

  assign in_tready = pipe_en;
  assign out_tdata = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_res};

endmodule

`default_nettype wire

// ----- rtl/core/lafc_abs_chain.sv -----
`default_nettype none

module lafc_abs_chain (
  input  logic                clk,
  input  logic                en,
  input  lafc_pkg::alpha_set_t alpha_i,
  output lafc_pkg::res_t      res_o
);
  import lafc_pkg::*;

  // round(prod / 255), halves up: floor((prod + 127) / 255), one correction step
  function automatic alpha_t div255_round(input logic [2*ALPHA_W-1:0] prod);
    logic [2*ALPHA_W-1:0] y;
    logic [ALPHA_W:0]     r;
    alpha_t               q0;
    y  = prod + (2*ALPHA_W)'(FULL_ALPHA >> 1);
    q0 = y[2*ALPHA_W-1:ALPHA_W];
    r  = {1'b0, y[ALPHA_W-1:0]} + {1'b0, q0};
    div255_round = (r >= {1'b0, FULL_ALPHA}) ? q0 + alpha_t'(1) : q0;
  endfunction

  logic [2*ALPHA_W-1:0] prod3_r, prod2_r, prod1_r;
  logic [2*ALPHA_W-1:0] prod2_nxt, prod1_nxt;
  alpha_t a2_s2_r, a2_s3_r;
  alpha_t a1_s2_r, a1_s3_r, a1_s4_r, a1_s5_r;
  alpha_t v3_s3_r, v3_s4_r, v3_s5_r, v3_s6_r, v3_s7_r;
  alpha_t v2_s5_r, v2_s6_r, v2_s7_r;
  alpha_t v1_s7_r;
  alpha_t rem_s3_r, rem_s4_r, rem_s5_r;
  alpha_t v3_nxt, v2_nxt, v1_nxt;

  always_comb begin
    v3_nxt    = div255_round(prod3_r);
    v2_nxt    = div255_round(prod2_r);
    v1_nxt    = div255_round(prod1_r);
    prod2_nxt = (2*ALPHA_W)'(a2_s3_r) * (2*ALPHA_W)'(rem_s3_r);
    prod1_nxt = (2*ALPHA_W)'(a1_s5_r) * (2*ALPHA_W)'(rem_s5_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // top overlay sees full visibility
      prod3_r  <= {alpha_i.a3, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, alpha_i.a3};
      a2_s2_r  <= alpha_i.a2;
      a1_s2_r  <= alpha_i.a1;

      v3_s3_r  <= v3_nxt;
      rem_s3_r <= FULL_ALPHA - v3_nxt;
      a2_s3_r  <= a2_s2_r;
      a1_s3_r  <= a1_s2_r;

      prod2_r  <= prod2_nxt;
      rem_s4_r <= rem_s3_r;
      v3_s4_r  <= v3_s3_r;
      a1_s4_r  <= a1_s3_r;

      v2_s5_r  <= v2_nxt;
      rem_s5_r <= rem_s4_r - v2_nxt;
      v3_s5_r  <= v3_s4_r;
      a1_s5_r  <= a1_s4_r;

      prod1_r  <= prod1_nxt;
      v2_s6_r  <= v2_s5_r;
      v3_s6_r  <= v3_s5_r;

      v1_s7_r  <= v1_nxt;
      v2_s7_r  <= v2_s6_r;
      v3_s7_r  <= v3_s6_r;
    end
  end

  assign res_o = '{sat: 1'b0, a3: v3_s7_r, a2: v2_s7_r, a1: v1_s7_r};

endmodule

`default_nettype wire

// ----- rtl/core/lafc_stk_lanes.sv -----
`default_nettype none

module lafc_stk_lanes (
  input  logic                clk,
  input  logic                en,
  input  lafc_pkg::alpha_set_t alpha_i,
  output lafc_pkg::res_t      res_o
);
  import lafc_pkg::*;

  localparam int unsigned LANES   = 3;
  localparam int unsigned NUM_W   = 17;
  localparam int unsigned DEN_W   = ALPHA_W + 1;
  localparam int unsigned STEPS   = 4;
  localparam int unsigned BITS_PS = ALPHA_W / STEPS;
  localparam logic [NUM_W-1:0] TWICE_FULL = NUM_W'(2 * 255);

  typedef struct packed {
    logic [NUM_W-1:0] p;
    logic [DEN_W-1:0] d;
    alpha_t           q;
    logic             sat;
    logic             live;
  } lane_t;

  alpha_t a_s2_r    [LANES];
  alpha_t den_s2_r  [LANES];
  logic   live_s2_r [LANES];
  alpha_t den_nxt   [LANES];
  logic   live_nxt  [LANES];

  lane_t lane_r   [STEPS+1][LANES];
  lane_t lane_nxt [STEPS+1][LANES];

  alpha_t r2, r1;
  logic   r2_pos, r1_pos;

  // remaining visibility per overlay, independent of the quotients
  always_comb begin
    r2     = FULL_ALPHA - alpha_i.a3;
    r2_pos = (r2 != '0);
    r1     = r2 - alpha_i.a2;
    r1_pos = r2_pos && (r2 > alpha_i.a2);
    den_nxt[2]  = FULL_ALPHA;
    live_nxt[2] = 1'b1;
    den_nxt[1]  = r2;
    live_nxt[1] = r2_pos;
    den_nxt[0]  = r1;
    live_nxt[0] = r1_pos;
  end

  // round(a*255/rem) = floor((510a + rem) / 2rem), two quotient bits a stage
  always_comb begin
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] shd;
    int               bi;
    for (int l = 0; l < LANES; l++) begin
      num = NUM_W'(a_s2_r[l]) * TWICE_FULL + NUM_W'(den_s2_r[l]);
      lane_nxt[0][l].p    = num;
      lane_nxt[0][l].d    = {den_s2_r[l], 1'b0};
      lane_nxt[0][l].q    = '0;
      lane_nxt[0][l].live = live_s2_r[l];
      lane_nxt[0][l].sat  = live_s2_r[l] && (num >= {den_s2_r[l], {DEN_W{1'b0}}});
    end
    for (int s = 0; s < STEPS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        lane_nxt[s+1][l] = lane_r[s][l];
        for (int b = 0; b < BITS_PS; b++) begin
          bi  = ALPHA_W - 1 - s * BITS_PS - b;
          shd = NUM_W'(lane_r[s][l].d) << bi;
          if (lane_nxt[s+1][l].p >= shd) begin
            lane_nxt[s+1][l].p     = lane_nxt[s+1][l].p - shd;
            lane_nxt[s+1][l].q[bi] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s2_r[0] <= alpha_i.a1;
      a_s2_r[1] <= alpha_i.a2;
      a_s2_r[2] <= alpha_i.a3;
      den_s2_r  <= den_nxt;
      live_s2_r <= live_nxt;
      lane_r    <= lane_nxt;
    end
  end

  alpha_t v_fin [LANES];
  logic   sat_any;

  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (!lane_r[STEPS][l].live) begin
        v_fin[l] = '0;
      end else if (lane_r[STEPS][l].sat) begin
        v_fin[l] = FULL_ALPHA;
      end else begin
        v_fin[l] = lane_r[STEPS][l].q;
      end
      sat_any = sat_any | lane_r[STEPS][l].sat;
    end
  end

  assign res_o = '{sat: sat_any, a3: v_fin[2], a2: v_fin[1], a1: v_fin[0]};

endmodule

`default_nettype wire

// ----- rtl/core/lafc_out_skid.sv -----
`default_nettype none

module lafc_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pipe_vld,
  input  lafc_pkg::res_t pipe_res,
  output logic           pipe_en,
  output logic           out_vld,
  output lafc_pkg::res_t out_res,
  input  logic           out_rdy
);
  import lafc_pkg::*;

  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_rdy) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = pipe_vld;
        out_res_nxt = pipe_res;
      end
    end else if (pipe_vld && !skid_vld_r) begin
      // output held: park the request leaving the pipe
      skid_vld_nxt = 1'b1;
      skid_res_nxt = pipe_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign pipe_en = !skid_vld_r;
  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

endmodule

`default_nettype wire

// ----- rtl/core/lafc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module lafc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lafc_pkg::OUT_DATA_W-1:0] out_tdata
);

  `ASSERT_CLK(a_rst_empty, clk, !rst_n |=> !out_tvalid && in_tready, "not empty after reset")
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled request changed")
  `ASSERT_CLKD(a_full_held, clk, rst_n, !in_tready |-> out_tvalid, "input stalled with output empty")
  `ASSERT_CLKD(a_drain, clk, rst_n, !in_tready && out_tready |=> in_tready, "input stall outlived output take")

endmodule

bind layer_alpha_format_convert_top lafc_checker u_lafc_checker (.*);

`default_nettype wire
